/* src/key_matrix_debounce_assert.svh */
// ----------------------------------------------------------------------------
// Key matrix debounce assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_ASSERT_SVH

// Same-cycle implication.
`define KMD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key matrix debounce: same-cycle check failed");

// Next-cycle implication.
`define KMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key matrix debounce: next-cycle check failed");

`endif

/* src/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// Key matrix debounce package
// Types, constants and the per-key debounce step shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package kmd_pkg;

    localparam int MAX_COLS     = 16;
    localparam int ROW_W        = 4;
    localparam int LEVEL_W      = 16;
    localparam int STEADY_W     = 7;
    localparam int THRESH_W     = 7;
    localparam int COLS_W       = 5;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int CNT_W        = 8;

    localparam int DEF_ROW_COUNT = 16;
    localparam int DEF_COL_COUNT = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_STEADY_LIMIT        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRANSIENT_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMNS_IN_USE      = 2'd2;

    localparam logic [STEADY_W-1:0] RST_STEADY_LIMIT        = 7'd8;
    localparam logic [THRESH_W-1:0] RST_TRANSIENT_THRESHOLD = 7'd4;
    localparam logic [COLS_W-1:0]   RST_COLUMNS_IN_USE      = 5'd16;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_RISING   = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_FALLING  = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t                   phase;
        logic signed [CNT_W-1:0]  counter;
    } key_state_t;

    typedef struct packed {
        key_state_t key;
        logic       event_flag;
    } key_step_t;

    localparam key_state_t KEY_RESET = '{
        phase:   PH_RELEASED,
        counter: -$signed({1'b0, RST_STEADY_LIMIT})
    };

    function automatic key_step_t key_step(
        input key_state_t              k,
        input logic                    active,
        input logic signed [CNT_W-1:0] s,
        input logic signed [CNT_W-1:0] t
    );
        logic signed [CNT_W-1:0] cnt;
        phase_t                  ph;
        logic                    ev;
        key_step_t               res;
        cnt = k.counter;
        ph  = k.phase;
        ev  = 1'b0;
        if (active)
        begin
            if (cnt < s)
                cnt = cnt + 8'sd1;
        end
        else
        begin
            if (cnt > -s)
                cnt = cnt - 8'sd1;
        end
        case (ph)
            PH_RELEASED:
            begin
                if (cnt >= -t)
                begin
                    cnt = '0;
                    ph  = PH_RISING;
                    ev  = 1'b1;
                end
            end
            PH_RISING:
            begin
                if (cnt == s)
                    ph = PH_PRESSED;
                else if (cnt == -s)
                begin
                    ph = PH_RELEASED;
                    ev = 1'b1;
                end
            end
            PH_PRESSED:
            begin
                if (cnt <= t)
                begin
                    cnt = '0;
                    ph  = PH_FALLING;
                    ev  = 1'b1;
                end
            end
            default:
            begin
                if (cnt == s)
                begin
                    ph = PH_PRESSED;
                    ev = 1'b1;
                end
                else if (cnt == -s)
                    ph = PH_RELEASED;
            end
        endcase
        res.key.counter = cnt;
        res.key.phase   = ph;
        res.event_flag  = ev;
        return res;
    endfunction

endpackage

`default_nettype wire

/* src/key_matrix_debounce.sv */
// ----------------------------------------------------------------------------
// Key matrix debounce
// Integrating-counter debouncer for a scanned key matrix, one row per word.
// ----------------------------------------------------------------------------
// The block takes one scanned row per cycle while the output is not stalled
// and returns one result word per row. A row is registered in stage s1 and
// its result in the output register; up to two words wait inside while the
// output is stalled. The rate is one word per cycle, set by the row-wide
// state memory, which is read when an in-range word is accepted and written
// back when that word leaves s1; a read of the row being written gets the
// new state through a bypass. Each row has a valid bit cleared by reset, so
// there is no clearing pass and the block is ready at once after reset.
// Configuration writes take effect immediately and are meant for idle periods.
`default_nettype none

`include "key_matrix_debounce_assert.svh"

module key_matrix_debounce
    import kmd_pkg::*;
#(
    parameter int ROW_COUNT = DEF_ROW_COUNT,
    parameter int COL_COUNT = DEF_COL_COUNT
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_write,
    input  wire  [CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0]   cfg_data,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [ROW_W-1:0]        row_index,
    input  wire  [LEVEL_W-1:0]      column_levels,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [ROW_W-1:0]        row_echo,
    output logic [LEVEL_W-1:0]      event_mask,
    output logic [LEVEL_W-1:0]      pressed_mask
);

    localparam int ADDR_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    logic [STEADY_W-1:0] steady_reg;
    logic [THRESH_W-1:0] threshold_reg;
    logic [COLS_W-1:0]   columns_reg;

    logic                s1_valid_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [LEVEL_W-1:0]  s1_levels_reg;
    logic                s1_in_range_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;

    logic                out_valid_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [LEVEL_W-1:0]  out_event_reg;
    logic [LEVEL_W-1:0]  out_pressed_reg;

    logic                s1_go;
    logic                in_fire;
    logic                in_range;
    logic [ADDR_W-1:0]   in_addr;
    logic                rd_en;
    logic                wr_en;

    key_state_t [COL_COUNT-1:0] old_keys;
    key_state_t [COL_COUNT-1:0] new_keys;
    logic [COL_COUNT-1:0]       event_bits;
    logic [COL_COUNT-1:0]       pressed_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steady_reg    <= RST_STEADY_LIMIT;
            threshold_reg <= RST_TRANSIENT_THRESHOLD;
            columns_reg   <= RST_COLUMNS_IN_USE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_STEADY_LIMIT:        steady_reg    <= STEADY_W'(cfg_data);
                REG_TRANSIENT_THRESHOLD: threshold_reg <= THRESH_W'(cfg_data);
                REG_COLUMNS_IN_USE:      columns_reg   <= COLS_W'(cfg_data);
                default:                 ;
            endcase
        end
    end

    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_fire  = in_valid && in_ready;
    assign in_range = (32'(row_index) < ROW_COUNT);
    assign in_addr  = ADDR_W'(row_index);
    assign rd_en    = in_fire && in_range;
    assign wr_en    = s1_go && s1_in_range_reg;

    kmd_state_mem #(
        .ROW_COUNT (ROW_COUNT),
        .COL_COUNT (COL_COUNT)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (in_addr),
        .rd_keys (old_keys),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_keys (new_keys)
    );

    kmd_row_update #(
        .COL_COUNT (COL_COUNT)
    ) u_row_update (
        .old_keys            (old_keys),
        .levels              (s1_levels_reg),
        .in_range            (s1_in_range_reg),
        .steady_limit        (steady_reg),
        .transient_threshold (threshold_reg),
        .columns_in_use      (columns_reg),
        .new_keys            (new_keys),
        .event_bits          (event_bits),
        .pressed_bits        (pressed_bits)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_row_reg      <= row_index;
            s1_levels_reg   <= column_levels;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= in_addr;
        end
        if (s1_go)
        begin
            out_row_reg     <= s1_row_reg;
            out_event_reg   <= LEVEL_W'(event_bits);
            out_pressed_reg <= LEVEL_W'(pressed_bits);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
            if (s1_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_echo     = out_row_reg;
    assign event_mask   = out_event_reg;
    assign pressed_mask = out_pressed_reg;

    `KMD_ASSERT_NOW(a_stall_blocks_input, s1_valid_reg && !s1_go, !in_ready)
    `KMD_ASSERT_NEXT(a_write_makes_result, wr_en, out_valid_reg)
    `KMD_ASSERT_NEXT(a_out_of_range_quiet, s1_go && !s1_in_range_reg,
                     (out_event_reg == '0) && (out_pressed_reg == '0))

endmodule

`default_nettype wire

/* src/kmd_state_mem.sv */
// ----------------------------------------------------------------------------
// Key state memory
// One row of key states per entry, a registered read, per-row valid
// bits that make an unwritten row read as the reset state, and a bypass for
// a read that meets a write to the same row.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_state_mem
    import kmd_pkg::*;
#(
    parameter int ROW_COUNT = DEF_ROW_COUNT,
    parameter int COL_COUNT = DEF_COL_COUNT
)
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  rd_en,
    input  wire  [((ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1)-1:0] rd_addr,
    output key_state_t [COL_COUNT-1:0]           rd_keys,
    input  wire                                  wr_en,
    input  wire  [((ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1)-1:0] wr_addr,
    input  key_state_t [COL_COUNT-1:0]           wr_keys
);

    key_state_t [COL_COUNT-1:0] mem [ROW_COUNT];

    logic [ROW_COUNT-1:0]       row_valid_reg;
    key_state_t [COL_COUNT-1:0] rd_data_reg;
    logic                       rd_valid_reg;
    logic                       fwd_hit_reg;
    key_state_t [COL_COUNT-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_keys;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_keys;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
            rd_keys = fwd_data_reg;
        else if (rd_valid_reg)
            rd_keys = rd_data_reg;
        else
            rd_keys = {COL_COUNT{KEY_RESET}};
    end

endmodule

`default_nettype wire

/* src/kmd_row_update.sv */
// ----------------------------------------------------------------------------
// Row update
// One debounce lane per column: steps every enabled key of the row and
// builds the event and pressed masks.
// ----------------------------------------------------------------------------
`default_nettype none

module kmd_row_update
    import kmd_pkg::*;
#(
    parameter int COL_COUNT = DEF_COL_COUNT
)
(
    input  key_state_t [COL_COUNT-1:0] old_keys,
    input  wire  [LEVEL_W-1:0]         levels,
    input  wire                        in_range,
    input  wire  [STEADY_W-1:0]        steady_limit,
    input  wire  [THRESH_W-1:0]        transient_threshold,
    input  wire  [COLS_W-1:0]          columns_in_use,
    output key_state_t [COL_COUNT-1:0] new_keys,
    output logic [COL_COUNT-1:0]       event_bits,
    output logic [COL_COUNT-1:0]       pressed_bits
);

    logic signed [CNT_W-1:0] s_eff;
    logic signed [CNT_W-1:0] t_eff;

    assign s_eff = (steady_limit == '0) ? 8'sd1 : $signed({1'b0, steady_limit});
    assign t_eff = $signed({1'b0, transient_threshold});

    for (genvar c = 0; c < COL_COUNT; c++)
    begin : g_lane
        localparam logic [COLS_W-1:0] COL_IDX = COLS_W'(c);
        logic      enable;
        key_step_t step;

        assign enable = in_range && (COL_IDX < columns_in_use);
        assign step   = key_step(old_keys[c], ~levels[c], s_eff, t_eff);

        assign new_keys[c]     = enable ? step.key : old_keys[c];
        assign event_bits[c]   = enable && step.event_flag;
        assign pressed_bits[c] = enable && ((step.key.phase == PH_RISING) ||
                                            (step.key.phase == PH_PRESSED));
    end

endmodule

`default_nettype wire

/* test/key_matrix_debounce_test.sv */
// ----------------------------------------------------------------------------
// Key matrix debounce testbench
// Sends scanned rows through the valid/ready input and predicts each result
// word with an independent per-key debounce model. Random idling on both
// sides, a long output stall and several register settings are covered.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_test;

    import kmd_pkg::*;

    localparam int NUM_KEYS    = DEF_ROW_COUNT * DEF_COL_COUNT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;

    typedef struct {
        logic [ROW_W-1:0]   row;
        logic [LEVEL_W-1:0] events;
        logic [LEVEL_W-1:0] pressed;
    } scan_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [ROW_W-1:0]       row_index;
    logic [LEVEL_W-1:0]     column_levels;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [ROW_W-1:0]       row_echo;
    logic [LEVEL_W-1:0]     event_mask;
    logic [LEVEL_W-1:0]     pressed_mask;

    logic [STEADY_W-1:0]     steady_setting;
    logic [THRESH_W-1:0]     threshold_setting;
    logic [COLS_W-1:0]       columns_setting;
    logic signed [CNT_W-1:0] key_tally [NUM_KEYS];
    phase_t                  key_state [NUM_KEYS];
    scan_result_t            expected_scans [$];
    logic [LEVEL_W-1:0]      settled_levels [DEF_ROW_COUNT];

    int mismatches    = 0;
    int in_idle_pct   = 15;
    int out_idle_pct  = 15;
    int hold_left     = 0;
    int hold_requests = 0;
    int holds_served  = 0;

    key_matrix_debounce dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .row_index     (row_index),
        .column_levels (column_levels),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .row_echo      (row_echo),
        .event_mask    (event_mask),
        .pressed_mask  (pressed_mask)
    );

    always #6 clk = ~clk;

    // A transient only settles on exact equality with the saturation limit.
    function automatic logic debounce_key(input int slot, input logic contact);
        int     limit;
        int     thresh;
        int     tally;
        phase_t ph;
        logic   changed;
        limit   = (steady_setting == '0) ? 1 : int'(steady_setting);
        thresh  = int'(threshold_setting);
        tally   = int'(key_tally[slot]);
        ph      = key_state[slot];
        changed = 1'b0;
        if (contact && tally < limit)
            tally++;
        else if (!contact && tally > -limit)
            tally--;
        case (ph)
            PH_RELEASED:
            begin
                if (tally >= -thresh)
                begin
                    tally   = 0;
                    ph      = PH_RISING;
                    changed = 1'b1;
                end
            end
            PH_RISING:
            begin
                if (tally == limit)
                    ph = PH_PRESSED;
                else if (tally == -limit)
                begin
                    ph      = PH_RELEASED;
                    changed = 1'b1;
                end
            end
            PH_PRESSED:
            begin
                if (tally <= thresh)
                begin
                    tally   = 0;
                    ph      = PH_FALLING;
                    changed = 1'b1;
                end
            end
            default:
            begin
                if (tally == limit)
                begin
                    ph      = PH_PRESSED;
                    changed = 1'b1;
                end
                else if (tally == -limit)
                    ph = PH_RELEASED;
            end
        endcase
        key_tally[slot] = tally[CNT_W-1:0];
        key_state[slot] = ph;
        return changed;
    endfunction

    function automatic void debounce_row(input logic [ROW_W-1:0] row,
                                         input logic [LEVEL_W-1:0] levels);
        scan_result_t res;
        int           used;
        int           slot;
        used        = (columns_setting > MAX_COLS) ? MAX_COLS : int'(columns_setting);
        res.row     = row;
        res.events  = '0;
        res.pressed = '0;
        for (int c = 0; c < used; c++)
        begin
            slot = int'(row) * DEF_COL_COUNT + c;
            res.events[c]  = debounce_key(slot, !levels[c]);
            res.pressed[c] = (key_state[slot] == PH_RISING) ||
                             (key_state[slot] == PH_PRESSED);
        end
        expected_scans.push_back(res);
    endfunction

    task automatic flag_mismatch(input string what, input logic [LEVEL_W-1:0] want,
                                 input logic [LEVEL_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch in %s: expected %h, got %h", what, want, got);
    endtask

    // Signals are stable at the falling edge, so a handshake seen here is
    // the one that completes at the next rising edge.
    always @(negedge clk)
    begin
        scan_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_scans.size() == 0)
                flag_mismatch("word with nothing expected, row", '0, row_echo);
            else
            begin
                want = expected_scans.pop_front();
                if (row_echo !== want.row)
                    flag_mismatch("row_echo", want.row, row_echo);
                if (event_mask !== want.events)
                    flag_mismatch("event_mask", want.events, event_mask);
                if (pressed_mask !== want.pressed)
                    flag_mismatch("pressed_mask", want.pressed, pressed_mask);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            out_ready    <= 1'b0;
            hold_left    <= HOLD_CYCLES - 1;
            holds_served <= hold_requests;
        end
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    task automatic send_row(input logic [ROW_W-1:0] row, input logic [LEVEL_W-1:0] levels);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        row_index     <= row;
        column_levels <= levels;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        debounce_row(row, levels);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_scans.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [STEADY_W-1:0] steady,
                              input logic [THRESH_W-1:0] thresh,
                              input logic [COLS_W-1:0] cols);
        logic [CFG_INDEX_W-1:0] idx [3];
        logic [CFG_DATA_W-1:0]  val [3];
        idx = '{REG_STEADY_LIMIT, REG_TRANSIENT_THRESHOLD, REG_COLUMNS_IN_USE};
        val = '{steady, thresh, CFG_DATA_W'(cols)};
        wait_idle();
        for (int i = 0; i < 3; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_write         <= 1'b0;
        steady_setting    = steady;
        threshold_setting = thresh;
        columns_setting   = cols;
    endtask

    task automatic test_reset_defaults();
        send_row(4'd15, 16'h0000);
        send_row(4'd0, 16'hFFFF);
        send_row(4'd7, 16'hAAAA);
        send_row(4'd15, 16'h5555);
    endtask

    // A steady count of zero acts as one, and a threshold above it makes a
    // settled key enter a transient at once, so every phase is reached fast.
    task automatic test_phase_walk();
        logic [LEVEL_W-1:0] walk [8];
        walk = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
                 16'hFFFF, 16'h0000, 16'hFFFF, 16'h5A5A};
        set_config(7'd0, 7'd126, 5'd16);
        foreach (walk[i])
            send_row(4'd3, walk[i]);
    endtask

    task automatic test_column_limits();
        set_config(7'd127, 7'd127, 5'd0);
        send_row(4'd9, 16'h0000);
        set_config(7'd127, 7'd127, 5'd1);
        send_row(4'd9, 16'h0000);
        set_config(7'd1, 7'd0, 5'd31);
        send_row(4'd9, 16'h0000);
    endtask

    task automatic test_output_stall();
        set_config(7'd3, 7'd1, 5'd16);
        in_idle_pct = 0;
        hold_requests++;
        repeat (40)
            send_row(4'($urandom_range(15)), 16'($urandom));
        in_idle_pct = 15;
    endtask

    // Each row follows a settled pattern that changes now and then, with
    // short bounces and some fully random scans mixed in.
    task automatic test_random_scans();
        logic [STEADY_W-1:0] steady;
        logic [ROW_W-1:0]    row;
        logic [LEVEL_W-1:0]  levels;
        foreach (settled_levels[r])
            settled_levels[r] = 16'($urandom);
        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0: set_config(7'd2, 7'd1, 5'd16);
                1: set_config(7'd1, 7'd0, 5'd16);
                6: set_config(7'd127, 7'd126, 5'd31);
                default:
                begin
                    steady = 7'($urandom_range(1, 10));
                    set_config(steady, 7'($urandom_range(0, steady + 1)),
                               ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd16);
                end
            endcase
            in_idle_pct  = (p == 0) ? 0 : 15;
            out_idle_pct = (p == 0) ? 0 : 15;
            repeat (215)
            begin
                row = 4'($urandom_range(15));
                if ($urandom_range(7) == 0)
                    settled_levels[row] ^= 16'($urandom & $urandom);
                levels = settled_levels[row];
                if ($urandom_range(5) == 0)
                    levels[$urandom_range(15)] ^= 1'b1;
                if ($urandom_range(19) == 0)
                    levels = 16'($urandom);
                send_row(row, levels);
            end
        end
        in_idle_pct  = 15;
        out_idle_pct = 15;
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_write         <= 1'b0;
        cfg_index         <= REG_STEADY_LIMIT;
        cfg_data          <= '0;
        in_valid          <= 1'b0;
        row_index         <= '0;
        column_levels     <= '1;
        steady_setting    = RST_STEADY_LIMIT;
        threshold_setting = RST_TRANSIENT_THRESHOLD;
        columns_setting   = RST_COLUMNS_IN_USE;
        foreach (key_tally[i])
        begin
            key_tally[i] = -8'sd8;
            key_state[i] = PH_RELEASED;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_phase_walk();
        test_column_limits();
        test_output_stall();
        test_random_scans();
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

/* key_matrix_debounce.f */
+incdir+src
src/kmd_pkg.sv
src/kmd_state_mem.sv
src/kmd_row_update.sv
src/key_matrix_debounce.sv
test/key_matrix_debounce_test.sv
